// File: hw/rtl/mfp_pkg.sv
// Shared types, mode codes and register indexes for the motor fault protection block.
package mfp_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int ErrW     = 12;
  localparam int WarnW    = 3;

  // Operating modes
  localparam logic [2:0] MODE_INIT     = 3'd0;
  localparam logic [2:0] MODE_ARMED    = 3'd1;
  localparam logic [2:0] MODE_RUNNING  = 3'd2;
  localparam logic [2:0] MODE_WINDDOWN = 3'd3;
  localparam logic [2:0] MODE_DISARMED = 3'd4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_PHASE_LIMIT  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BUS_LIMIT    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SUM_LIMIT    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_VBUS_UPPER   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_VBUS_LOWER   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SPEED_LIMIT  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_UV_STACK_THR = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_STACKING_ON  = 3'd7;

  // Register reset values
  localparam logic [14:0] PHASE_LIMIT_RST  = 15'd2400;
  localparam logic [14:0] BUS_LIMIT_RST    = 15'd1600;
  localparam logic [15:0] SUM_LIMIT_RST    = 16'd1920;
  localparam logic [15:0] VBUS_UPPER_RST   = 16'd30720;
  localparam logic [15:0] VBUS_LOWER_RST   = 16'd6400;
  localparam logic [14:0] SPEED_LIMIT_RST  = 15'd16000;
  localparam logic [15:0] UV_STACK_THR_RST = 16'd0;

  // Error mask bit positions
  localparam int ERR_OV_BIT    = 8;
  localparam int ERR_UV_BIT    = 9;
  localparam int ERR_SPEED_BIT = 10;
  localparam int ERR_ADC_BIT   = 11;

  typedef struct packed {
    logic [2:0]         mode;
    logic               clear_all;
    logic [2:0]         warn_clear_mask;
    logic signed [15:0] cur_a;
    logic signed [15:0] cur_b;
    logic signed [15:0] cur_c;
    logic signed [15:0] cur_bus;
    logic [15:0]        volt_bus;
    logic [15:0]        stack_mean;
    logic signed [15:0] speed;
    logic               ext_fault;
    logic [1:0]         ext_warn;
  } mfp_in_t;

  typedef struct packed {
    logic [ErrW-1:0]  error_mask;
    logic [WarnW-1:0] warning_mask;
    logic             gate_on;
  } mfp_out_t;

endpackage

// File: hw/rtl/motor_fault_protection_core.sv
// Top level of the motor drive fault protection block: limit checks, sticky masks, gate latch.
//
//  channel | ports                              | direction | beat
//  --------+------------------------------------+-----------+---------------------------
//  in      | in_valid, in_ready, in_data        | sink      | one sample set per tick
//  out     | out_valid, out_ready, out_data     | source    | masks and gate after tick
//  cfg     | cfg_valid, cfg_ready, cfg_index,   | sink      | one limit register write
//          | cfg_data                           |           |
//
// An input beat lands in the input register; from there the checks and sticky updates
// run in one pass and the result lands in the output register. One beat is taken
// every cycle while the output is not stalled. The sticky masks, previous mode and
// gate latch advance only when a beat moves from the input to the output register.
// A stalled output holds both registers; the input register still takes a beat while
// it is empty. Synchronous reset empties both registers, clears the sticky state and
// loads the limit registers with their defaults. Configuration writes are taken at once.
module motor_fault_protection_core
  import mfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mfp_in_t             in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mfp_out_t            out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Limit registers
  logic [14:0] phase_limit_r;
  logic [14:0] bus_limit_r;
  logic [15:0] sum_limit_r;
  logic [15:0] vbus_upper_r;
  logic [15:0] vbus_lower_r;
  logic [14:0] speed_limit_r;
  logic [15:0] uv_stack_thr_r;
  logic        stacking_on_r;

  // Pipeline registers
  logic     s1_valid_r;
  mfp_in_t  s1_data_r;
  logic     out_valid_r;
  mfp_out_t out_data_r;

  // Sticky state
  logic [ErrW-1:0]  err_r,  err_nxt;
  logic [WarnW-1:0] warn_r, warn_nxt;
  logic [2:0]       prev_mode_r;
  logic             gate_r, gate_nxt;

  logic advance;

  assign cfg_ready = 1'b1;
  // Move the held beat forward whenever the output slot is free or being emptied.
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_limit_r  <= PHASE_LIMIT_RST;
      bus_limit_r    <= BUS_LIMIT_RST;
      sum_limit_r    <= SUM_LIMIT_RST;
      vbus_upper_r   <= VBUS_UPPER_RST;
      vbus_lower_r   <= VBUS_LOWER_RST;
      speed_limit_r  <= SPEED_LIMIT_RST;
      uv_stack_thr_r <= UV_STACK_THR_RST;
      stacking_on_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PHASE_LIMIT:  phase_limit_r  <= cfg_data[14:0];
        REG_BUS_LIMIT:    bus_limit_r    <= cfg_data[14:0];
        REG_SUM_LIMIT:    sum_limit_r    <= cfg_data;
        REG_VBUS_UPPER:   vbus_upper_r   <= cfg_data;
        REG_VBUS_LOWER:   vbus_lower_r   <= cfg_data;
        REG_SPEED_LIMIT:  speed_limit_r  <= cfg_data[14:0];
        REG_UV_STACK_THR: uv_stack_thr_r <= cfg_data;
        REG_STACKING_ON:  stacking_on_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Checks on the held beat
  logic signed [16:0] ph_lim_s, bus_lim_s;
  logic [7:0]         cur_trips;
  logic signed [17:0] phase_sum;
  logic [16:0]        sum_mag;
  logic [15:0]        speed_mag;
  logic               active, clear_honored;
  logic               ov_trip, uv_trip, speed_trip, sum_warn;
  logic [ErrW-1:0]    trips;
  logic [ErrW-1:0]    err_base, err_chk;
  logic [WarnW-1:0]   warn_base;

  always_comb begin
    ph_lim_s  = signed'({2'b00, phase_limit_r});
    bus_lim_s = signed'({2'b00, bus_limit_r});

    cur_trips[0] = 17'(s1_data_r.cur_a)   >  ph_lim_s;
    cur_trips[1] = 17'(s1_data_r.cur_a)   < -ph_lim_s;
    cur_trips[2] = 17'(s1_data_r.cur_b)   >  ph_lim_s;
    cur_trips[3] = 17'(s1_data_r.cur_b)   < -ph_lim_s;
    cur_trips[4] = 17'(s1_data_r.cur_c)   >  ph_lim_s;
    cur_trips[5] = 17'(s1_data_r.cur_c)   < -ph_lim_s;
    cur_trips[6] = 17'(s1_data_r.cur_bus) >  bus_lim_s;
    cur_trips[7] = 17'(s1_data_r.cur_bus) < -bus_lim_s;

    // Exact three-way sum; magnitude fits 17 bits.
    phase_sum = 18'(s1_data_r.cur_a) + 18'(s1_data_r.cur_b) + 18'(s1_data_r.cur_c);
    sum_mag   = phase_sum[17] ? 17'(-phase_sum) : phase_sum[16:0];
    sum_warn  = sum_mag > {1'b0, sum_limit_r};

    speed_mag  = s1_data_r.speed[15] ? 16'(-s1_data_r.speed) : 16'(s1_data_r.speed);
    speed_trip = speed_mag > {1'b0, speed_limit_r};

    active  = (s1_data_r.mode == MODE_RUNNING) || (s1_data_r.mode == MODE_WINDDOWN);
    ov_trip = s1_data_r.volt_bus > vbus_upper_r;
    uv_trip = active && (s1_data_r.volt_bus < vbus_lower_r) &&
              ((s1_data_r.stack_mean >= uv_stack_thr_r) || !stacking_on_r);

    trips                = '0;
    trips[7:0]           = cur_trips;
    trips[ERR_OV_BIT]    = ov_trip;
    trips[ERR_UV_BIT]    = uv_trip;
    trips[ERR_SPEED_BIT] = speed_trip;

    // Clear requests apply before this tick's checks.
    clear_honored = s1_data_r.clear_all &&
                    ((s1_data_r.mode == MODE_INIT) || (s1_data_r.mode == MODE_DISARMED));
    if (clear_honored) begin
      err_base  = '0;
      warn_base = '0;
    end else begin
      err_base  = err_r;
      warn_base = warn_r & ~s1_data_r.warn_clear_mask;
    end

    err_chk = err_base | trips;

    // Gate: close on armed-to-active with a clean mask, hold while clean and active,
    // drop otherwise and on any trip or external fault this tick.
    if (active && (err_chk == '0)) begin
      gate_nxt = (prev_mode_r == MODE_ARMED) ? 1'b1 : gate_r;
    end else begin
      gate_nxt = 1'b0;
    end
    if ((trips != '0) || s1_data_r.ext_fault) begin
      gate_nxt = 1'b0;
    end

    err_nxt              = err_chk;
    err_nxt[ERR_ADC_BIT] = err_chk[ERR_ADC_BIT] | s1_data_r.ext_fault;
    warn_nxt             = warn_base | {s1_data_r.ext_warn, sum_warn};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      err_r       <= '0;
      warn_r      <= '0;
      prev_mode_r <= MODE_INIT;
      gate_r      <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          err_r       <= err_nxt;
          warn_r      <= warn_nxt;
          prev_mode_r <= s1_data_r.mode;
          gate_r      <= gate_nxt;
        end
      end
    end
  end

  // Payload registers: load on a taken beat, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (advance && s1_valid_r) begin
      out_data_r.error_mask   <= err_nxt;
      out_data_r.warning_mask <= warn_nxt;
      out_data_r.gate_on      <= gate_nxt;
    end
  end

endmodule

// File: hw/rtl/mfp_checker.sv
// Port-level checker for the motor fault protection block, with its bind.
module mfp_checker
  import mfp_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input mfp_out_t out_data
);

  // An enabled gate never coexists with a latched error.
  a_gate_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.gate_on |-> out_data.error_mask == '0)
    else $error("gate enabled with errors latched");

  // A free output side always lets the input side take a beat.
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind motor_fault_protection_core mfp_checker u_mfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
